// ===== rtl/i2ctcf_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C target command framer package
// Shared constants, event codes and the reply store request type.
// ----------------------------------------------------------------------------
package i2ctcf_pkg;

  localparam int unsigned BufferDepthDefault = 16;
  localparam int unsigned ReplyDepth = 16;
  localparam int unsigned ReplyAw = 4;
  localparam int unsigned MaxResults = 16;

  localparam logic [7:0] NoCommandReset = 8'hFF;

  localparam logic [2:0] OpWrAddr   = 3'd0;
  localparam logic [2:0] OpRxByte   = 3'd1;
  localparam logic [2:0] OpStop     = 3'd2;
  localparam logic [2:0] OpRdAddr   = 3'd3;
  localparam logic [2:0] OpTxAcked  = 3'd4;
  localparam logic [2:0] OpOther    = 3'd5;
  localparam logic [2:0] OpLoadByte = 3'd6;
  localparam logic [2:0] OpSetLen   = 3'd7;

  typedef struct packed {
    logic               we;
    logic [ReplyAw-1:0] waddr;
    logic [7:0]         wdata;
    logic [ReplyAw-1:0] raddr;
  } reply_req_t;

endpackage

// ===== rtl/i2ctcf_param_mem.sv =====
// ----------------------------------------------------------------------------
// I2C target command framer parameter store
// Single-port write, registered read memory holding the parameter bytes.
// ----------------------------------------------------------------------------
module i2ctcf_param_mem #(
  parameter int unsigned BUFFER_DEPTH = i2ctcf_pkg::BufferDepthDefault,
  localparam int unsigned Aw = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/i2ctcf_reply_mem.sv =====
// ----------------------------------------------------------------------------
// I2C target command framer reply store
// Registered read memory whose entries read as zero until first written.
// ----------------------------------------------------------------------------
module i2ctcf_reply_mem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2ctcf_pkg::reply_req_t req_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [i2ctcf_pkg::ReplyDepth];
  logic [i2ctcf_pkg::ReplyDepth-1:0] valid_q;
  logic [7:0] mem_rd_q;
  logic       rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    mem_rd_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdata_q <= 1'b0;
    end else begin
      rdata_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q ? mem_rd_q : 8'h00;

endmodule

// ===== rtl/i2ctcf_seq_unused_guard.sv =====
// ----------------------------------------------------------------------------
// I2C target command framer shared step unit
// The one incrementer and limit compare that the sequencer reuses for the
// parameter count, the reply pointer and the delivery index.
// ----------------------------------------------------------------------------
module i2ctcf_seq_unused_guard #(
  parameter int unsigned Iw = 6
) (
  input  logic [Iw-1:0] operand_i,
  input  logic [Iw-1:0] limit_i,
  output logic [Iw-1:0] sum_o,
  output logic          below_o
);

  assign sum_o   = operand_i + Iw'(1);
  assign below_o = (sum_o < limit_i);

endmodule

// ===== rtl/i2c_target_command_framer_core.sv =====
// ----------------------------------------------------------------------------
// I2C target command framer
// Frames classified I2C bus events into commands with parameters and
// replays a loaded reply on reads.
// ----------------------------------------------------------------------------
// Usage: bus events enter on the input channel (in_valid_i, in_stall_o) and
// results leave on the output channel (out_valid_o, out_stall_i). An item is
// taken when valid is high and stall is low. The user writes the no-command
// code via cfg_we_i and cfg_wdata_i while the block is idle, which is not enforced.
// The block handles one item at a time under a small sequencer that drives a
// single shared incrementer and compare; in_stall_o is high until the last
// result of the current item has been taken.
// Sequence: a bus response goes from the decode state to the result register;
// a read response passes decode and a reply read state first. A stop with
// parameters passes decode, then a parameter read and a result state for
// each of up to 16 results, each further one starting once the previous one
// is taken. Reply load items produce no result and free the input after decode.
// When the receiver stalls, the result register simply holds its item.
// Reset initialises all control state and marks every reply entry as zero; no
// clearing pass is needed, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module i2c_target_command_framer_core #(
  parameter int unsigned BUFFER_DEPTH = i2ctcf_pkg::BufferDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic [3:0] reply_index_i,
  input  logic [7:0] reply_byte_i,
  input  logic [4:0] reply_length_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic       acknowledge_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] command_o,
  output logic [4:0] param_count_o,
  output logic [3:0] param_index_o,
  output logic [7:0] param_byte_o,
  output logic       last_o
);

  localparam int unsigned Rcw = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned Aw  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned Iw  = ((Rcw > 5) ? Rcw : 5) + 1;

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SDecode = 2'd1;
  localparam logic [1:0] SRead   = 2'd2;
  localparam logic [1:0] SOut    = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [7:0]     no_cmd_q;
  logic [2:0]     op_q;
  logic [7:0]     rx_q;
  logic [3:0]     ridx_q;
  logic [7:0]     rbyte_q;
  logic [4:0]     rlen_q;
  logic [7:0]     command_q, command_d;
  logic [Rcw-1:0] rx_count_q, rx_count_d;
  logic [4:0]     reply_len_q, reply_len_d;
  logic [4:0]     reply_ptr_q, reply_ptr_d;
  logic           armed_q, armed_d;
  logic [3:0]     idx_q, idx_d;

  logic           kind_q, kind_d;
  logic           ack_q, ack_d;
  logic [7:0]     tx_q, tx_d;
  logic [7:0]     cmd_out_q, cmd_out_d;
  logic [4:0]     count_q, count_d;
  logic [3:0]     pidx_q, pidx_d;
  logic [7:0]     pbyte_q, pbyte_d;
  logic           last_q, last_d;

  logic [Iw-1:0]  inc_a, inc_limit, inc_sum;
  logic           inc_below;
  logic [Iw-1:0]  rx_ext;
  logic [4:0]     n_clip;
  logic [4:0]     ptr_next;
  logic           in_acc, out_acc;

  logic           pm_we;
  logic [Aw-1:0]  pm_waddr, pm_raddr;
  logic [Aw+3:0]  pm_raddr_wide;
  logic [7:0]     pm_rdata;
  i2ctcf_pkg::reply_req_t rm_req;
  logic [7:0]     rm_rdata;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);

  assign rx_ext = Iw'(rx_count_q);
  assign n_clip = (rx_ext > Iw'(i2ctcf_pkg::MaxResults)) ? 5'd16 : rx_ext[4:0];

  always_comb begin
    inc_a     = Iw'(idx_q);
    inc_limit = Iw'(count_q);
    case (state_q)
      SDecode: begin
        inc_a     = rx_ext;
        inc_limit = Iw'(BUFFER_DEPTH);
      end
      SRead: begin
        if (op_q == i2ctcf_pkg::OpStop) begin
          inc_a     = Iw'(idx_q);
          inc_limit = Iw'(count_q);
        end else begin
          inc_a     = Iw'(reply_ptr_q);
          inc_limit = Iw'(reply_len_q);
        end
      end
      default: begin
        inc_a     = Iw'(idx_q);
        inc_limit = Iw'(count_q);
      end
    endcase
  end

  i2ctcf_seq_unused_guard #(
    .Iw(Iw)
  ) u_step (
    .operand_i(inc_a),
    .limit_i  (inc_limit),
    .sum_o    (inc_sum),
    .below_o  (inc_below)
  );

  assign ptr_next = reply_ptr_q[4] ? reply_ptr_q : inc_sum[4:0];

  always_comb begin
    state_d     = state_q;
    command_d   = command_q;
    rx_count_d  = rx_count_q;
    reply_len_d = reply_len_q;
    reply_ptr_d = reply_ptr_q;
    armed_d     = armed_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    ack_d       = ack_q;
    tx_d        = tx_q;
    cmd_out_d   = cmd_out_q;
    count_d     = count_q;
    pidx_d      = pidx_q;
    pbyte_d     = pbyte_q;
    last_d      = last_q;
    pm_we       = 1'b0;
    rm_req.we   = 1'b0;
    rm_req.waddr = ridx_q;
    rm_req.wdata = rbyte_q;
    rm_req.raddr = reply_ptr_q[3:0];
    case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = SDecode;
        end
      end
      SDecode: begin
        kind_d    = 1'b0;
        ack_d     = 1'b1;
        tx_d      = 8'h00;
        cmd_out_d = 8'h00;
        count_d   = 5'd0;
        pidx_d    = 4'd0;
        pbyte_d   = 8'h00;
        last_d    = 1'b0;
        idx_d     = 4'd0;
        state_d   = SOut;
        case (op_q)
          i2ctcf_pkg::OpWrAddr: begin
            command_d   = no_cmd_q;
            rx_count_d  = '0;
            reply_len_d = 5'd0;
            armed_d     = 1'b0;
          end
          i2ctcf_pkg::OpRxByte: begin
            if (command_q == no_cmd_q) begin
              command_d = rx_q;
            end else if (rx_ext < Iw'(BUFFER_DEPTH)) begin
              pm_we      = 1'b1;
              rx_count_d = inc_sum[Rcw-1:0];
              ack_d      = inc_below;
            end else begin
              ack_d = 1'b0;
            end
          end
          i2ctcf_pkg::OpStop: begin
            kind_d    = 1'b1;
            cmd_out_d = command_q;
            count_d   = n_clip;
            if (n_clip == 5'd0) begin
              last_d = 1'b1;
            end else begin
              state_d = SRead;
            end
            if (reply_len_q != 5'd0) begin
              reply_ptr_d = 5'd0;
              armed_d     = 1'b1;
            end
          end
          i2ctcf_pkg::OpRdAddr, i2ctcf_pkg::OpTxAcked: begin
            state_d = SRead;
          end
          i2ctcf_pkg::OpLoadByte: begin
            rm_req.we = 1'b1;
            state_d   = SIdle;
          end
          i2ctcf_pkg::OpSetLen: begin
            reply_len_d = (rlen_q > 5'd16) ? 5'd16 : rlen_q;
            if (rlen_q != 5'd0) begin
              reply_ptr_d = 5'd0;
              armed_d     = 1'b1;
            end
            state_d = SIdle;
          end
          default: begin
          end
        endcase
      end
      SRead: begin
        state_d = SOut;
        if (op_q == i2ctcf_pkg::OpStop) begin
          pidx_d  = idx_q;
          pbyte_d = pm_rdata;
          last_d  = (inc_sum == Iw'(count_q));
        end else if (armed_q) begin
          tx_d        = reply_ptr_q[4] ? 8'h00 : rm_rdata;
          reply_ptr_d = ptr_next;
          ack_d       = (ptr_next < reply_len_q);
        end else begin
          tx_d  = 8'h00;
          ack_d = 1'b0;
        end
      end
      SOut: begin
        if (out_acc) begin
          if (kind_q && !last_q) begin
            idx_d   = inc_sum[3:0];
            state_d = SRead;
          end else begin
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign pm_waddr      = rx_count_q[Aw-1:0];
  assign pm_raddr_wide = {{Aw{1'b0}}, idx_d};
  assign pm_raddr      = pm_raddr_wide[Aw-1:0];

  i2ctcf_param_mem #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_param_mem (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(rx_q),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  i2ctcf_reply_mem u_reply_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rm_req),
    .rdata_o(rm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      no_cmd_q    <= i2ctcf_pkg::NoCommandReset;
      command_q   <= 8'h00;
      rx_count_q  <= '0;
      reply_len_q <= 5'd0;
      reply_ptr_q <= 5'd0;
      armed_q     <= 1'b1;
      idx_q       <= 4'd0;
      kind_q      <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= 5'd0;
    end else begin
      state_q     <= state_d;
      command_q   <= command_d;
      rx_count_q  <= rx_count_d;
      reply_len_q <= reply_len_d;
      reply_ptr_q <= reply_ptr_d;
      armed_q     <= armed_d;
      idx_q       <= idx_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      count_q     <= count_d;
      if (cfg_we_i) begin
        no_cmd_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= opcode_i;
      rx_q    <= rx_byte_i;
      ridx_q  <= reply_index_i;
      rbyte_q <= reply_byte_i;
      rlen_q  <= reply_length_i;
    end
    ack_q     <= ack_d;
    tx_q      <= tx_d;
    cmd_out_q <= cmd_out_d;
    pidx_q    <= pidx_d;
    pbyte_q   <= pbyte_d;
  end

  assign kind_o        = kind_q;
  assign acknowledge_o = ack_q;
  assign tx_byte_o     = tx_q;
  assign command_o     = cmd_out_q;
  assign param_count_o = count_q;
  assign param_index_o = pidx_q;
  assign param_byte_o  = pbyte_q;
  assign last_o        = last_q;

  a_busy_while_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("Input not stalled while a result is pending.");

  a_rx_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_ext <= Iw'(BUFFER_DEPTH))
    else $error("Parameter count ran past the store depth.");

  a_reply_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_ptr_q <= 5'd16)
    else $error("Reply pointer ran past the reply store.");

  a_delivery_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o && param_count_o != 5'd0) |->
      ({1'b0, param_index_o} < param_count_o))
    else $error("Delivered index not below the parameter count.");

  a_delivery_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && kind_o && !last_o) |=> (state_q == SRead))
    else $error("Delivery run stopped before its last item.");

endmodule

// ===== tb/i2c_target_command_framer_core_tb.sv =====
// ----------------------------------------------------------------------------
// I2C target command framer testbench
// Sends classified bus events and reply loads into the framer and predicts
// every bus response and delivery item. Each result is checked in order
// against the prediction, with random idling on both channels, a long
// receiver hold-off and several settings of the no-command code.
// ----------------------------------------------------------------------------
module i2c_target_command_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles = 12;

  typedef struct packed {
    logic       kind;
    logic       ack;
    logic [7:0] tx;
    logic [7:0] cmd;
    logic [4:0] cnt;
    logic [3:0] idx;
    logic [7:0] pbyte;
    logic       last;
  } frame_item_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] opcode_i;
  logic [7:0] rx_byte_i;
  logic [3:0] reply_index_i;
  logic [7:0] reply_byte_i;
  logic [4:0] reply_length_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic       acknowledge_o;
  logic [7:0] tx_byte_o;
  logic [7:0] command_o;
  logic [4:0] param_count_o;
  logic [3:0] param_index_o;
  logic [7:0] param_byte_o;
  logic       last_o;

  logic [7:0] no_cmd_code;
  logic [7:0] cmd_seen;
  logic [4:0] param_fill;
  logic [7:0] param_mem [i2ctcf_pkg::BufferDepthDefault];
  logic [7:0] reply_mem [i2ctcf_pkg::ReplyDepth];
  logic [4:0] reply_limit;
  logic [4:0] reply_pos;
  logic       reply_live;

  frame_item_t due_results[$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int hold_request = 0;

  i2c_target_command_framer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .rx_byte_i      (rx_byte_i),
    .reply_index_i  (reply_index_i),
    .reply_byte_i   (reply_byte_i),
    .reply_length_i (reply_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .acknowledge_o  (acknowledge_o),
    .tx_byte_o      (tx_byte_o),
    .command_o      (command_o),
    .param_count_o  (param_count_o),
    .param_index_o  (param_index_o),
    .param_byte_o   (param_byte_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void predict_event(input logic [2:0] op, input logic [7:0] rxb,
                                        input logic [3:0] ridx, input logic [7:0] rbyte,
                                        input logic [4:0] rlen);
    frame_item_t r;
    r = '0;
    case (op)
      i2ctcf_pkg::OpWrAddr: begin
        cmd_seen = no_cmd_code;
        param_fill = '0;
        reply_limit = '0;
        reply_live = 1'b0;
        r.ack = 1'b1;
        due_results.push_back(r);
      end
      i2ctcf_pkg::OpRxByte: begin
        if (cmd_seen == no_cmd_code) begin
          cmd_seen = rxb;
          r.ack = 1'b1;
        end else if (param_fill < i2ctcf_pkg::BufferDepthDefault) begin
          param_mem[param_fill[3:0]] = rxb;
          param_fill = param_fill + 5'd1;
          r.ack = (param_fill < i2ctcf_pkg::BufferDepthDefault);
        end else begin
          r.ack = 1'b0;
        end
        due_results.push_back(r);
      end
      i2ctcf_pkg::OpStop: begin
        r.kind = 1'b1;
        r.ack = 1'b1;
        r.cmd = cmd_seen;
        if (param_fill == 0) begin
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          for (int i = 0; i < int'(param_fill); i++) begin
            r.cnt = param_fill;
            r.idx = 4'(i);
            r.pbyte = param_mem[i];
            r.last = (i == int'(param_fill) - 1);
            due_results.push_back(r);
          end
        end
        if (reply_limit != 0) begin
          reply_pos = '0;
          reply_live = 1'b1;
        end
      end
      i2ctcf_pkg::OpRdAddr, i2ctcf_pkg::OpTxAcked: begin
        if (reply_live) begin
          if (reply_pos < i2ctcf_pkg::ReplyDepth) begin
            r.tx = reply_mem[reply_pos[3:0]];
            reply_pos = reply_pos + 5'd1;
          end
          r.ack = (reply_pos < reply_limit);
        end
        due_results.push_back(r);
      end
      i2ctcf_pkg::OpLoadByte: begin
        reply_mem[ridx] = rbyte;
      end
      i2ctcf_pkg::OpSetLen: begin
        reply_limit = (rlen > 5'd16) ? 5'd16 : rlen;
        if (reply_limit != 0) begin
          reply_pos = '0;
          reply_live = 1'b1;
        end
      end
      default: begin
        r.ack = 1'b1;
        due_results.push_back(r);
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  task automatic send_event(input logic [2:0] op, input logic [7:0] rxb,
                            input logic [3:0] ridx, input logic [7:0] rbyte,
                            input logic [4:0] rlen);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    opcode_i <= op;
    rx_byte_i <= rxb;
    reply_index_i <= ridx;
    reply_byte_i <= rbyte;
    reply_length_i <= rlen;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_event(op, rxb, ridx, rbyte, rlen);
    items_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    send_event(op, 8'($urandom), 4'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic send_rx(input logic [7:0] rxb);
    send_event(i2ctcf_pkg::OpRxByte, rxb, 4'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic send_set_len(input logic [4:0] rlen);
    send_event(i2ctcf_pkg::OpSetLen, 8'($urandom), 4'($urandom), 8'($urandom), rlen);
  endtask

  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_no_command(input logic [7:0] code);
    drain();
    cfg_wdata_i <= code;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    no_cmd_code = code;
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_transfer();
    int n;
    if ($urandom_range(0, 9) != 0) send_op(i2ctcf_pkg::OpWrAddr);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: n = $urandom_range(0, 5);
      7, 8: n = $urandom_range(6, 15);
      default: n = $urandom_range(16, 18);
    endcase
    if ($urandom_range(0, 7) == 0) send_rx(no_cmd_code);
    send_rx(rand_byte());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_op(i2ctcf_pkg::OpOther);
      send_rx(rand_byte());
    end
    if ($urandom_range(0, 3) == 0) send_set_len(5'($urandom_range(0, 18)));
    if ($urandom_range(0, 9) != 0) send_op(i2ctcf_pkg::OpStop);
  endtask

  task automatic read_transfer();
    int reads;
    repeat ($urandom_range(0, 4)) begin
      send_event(i2ctcf_pkg::OpLoadByte, 8'($urandom), 4'($urandom), rand_byte(),
                 5'($urandom));
    end
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 7) == 0) send_set_len(5'($urandom_range(17, 31)));
      else send_set_len(5'($urandom_range(0, 16)));
    end
    send_op(i2ctcf_pkg::OpRdAddr);
    reads = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
    repeat (reads) send_op(i2ctcf_pkg::OpTxAcked);
    if ($urandom_range(0, 1) == 1) send_op(i2ctcf_pkg::OpStop);
  endtask

  task automatic test_full_store();
    send_op(i2ctcf_pkg::OpWrAddr);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    repeat (15) send_rx(rand_byte());
    send_op(i2ctcf_pkg::OpStop);
  endtask

  task automatic test_stop_and_reply();
    send_op(i2ctcf_pkg::OpWrAddr);
    send_op(i2ctcf_pkg::OpStop);
    send_op(i2ctcf_pkg::OpRdAddr);
    send_event(i2ctcf_pkg::OpLoadByte, 8'($urandom), 4'd15, 8'hFF, 5'($urandom));
    send_event(i2ctcf_pkg::OpLoadByte, 8'($urandom), 4'd0, 8'h00, 5'($urandom));
    send_set_len(5'd31);
    send_op(i2ctcf_pkg::OpRdAddr);
    send_op(i2ctcf_pkg::OpTxAcked);
    send_set_len(5'd0);
    send_op(i2ctcf_pkg::OpTxAcked);
    send_op(i2ctcf_pkg::OpOther);
  endtask

  task automatic test_backpressure();
    hold_request = 150;
    send_op(i2ctcf_pkg::OpWrAddr);
    repeat (6) send_rx(rand_byte());
    send_op(i2ctcf_pkg::OpStop);
    send_op(i2ctcf_pkg::OpOther);
    drain();
  endtask

  task automatic test_random_phase(input logic [7:0] code, input int count);
    int stop_at;
    set_no_command(code);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: write_transfer();
        6, 7, 8: read_transfer();
        default: repeat ($urandom_range(1, 3)) send_op(3'($urandom));
      endcase
    end
  endtask

  initial begin
    frame_item_t want;
    frame_item_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {kind_o, acknowledge_o, tx_byte_o, command_o, param_count_o,
               param_index_o, param_byte_o, last_o};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, got);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(got.kind));
          check_field("acknowledge", 8'(want.ack), 8'(got.ack));
          check_field("tx_byte", want.tx, got.tx);
          check_field("command", want.cmd, got.cmd);
          check_field("param_count", 8'(want.cnt), 8'(got.cnt));
          check_field("param_index", 8'(want.idx), 8'(got.idx));
          check_field("param_byte", want.pbyte, got.pbyte);
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
    end
  end

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    out_stall_i <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 8'h00;
    in_valid_i <= 1'b0;
    opcode_i <= i2ctcf_pkg::OpOther;
    rx_byte_i <= 8'h00;
    reply_index_i <= 4'h0;
    reply_byte_i <= 8'h00;
    reply_length_i <= 5'h00;
    no_cmd_code = i2ctcf_pkg::NoCommandReset;
    cmd_seen = 8'h00;
    param_fill = '0;
    reply_limit = '0;
    reply_pos = '0;
    reply_live = 1'b1;
    foreach (param_mem[i]) param_mem[i] = 8'h00;
    foreach (reply_mem[i]) reply_mem[i] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_store();
    test_stop_and_reply();
    test_backpressure();
    test_random_phase(8'h00, 20);
    test_random_phase(8'($urandom_range(1, 254)), 22);
    test_random_phase(8'hFF, 20);
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2ctcf_pkg.sv
rtl/i2ctcf_param_mem.sv
rtl/i2ctcf_reply_mem.sv
rtl/i2ctcf_seq_unused_guard.sv
rtl/i2c_target_command_framer_core.sv
tb/i2c_target_command_framer_core_tb.sv
